FILE: hw/rtl/gsup_pkg.sv
// ----------------------------------------------------------------------------
// gsup_pkg
// Shared types and the default-alphabet ROM for the septet unpacker.
// ----------------------------------------------------------------------------
package gsup_pkg;

    localparam int unsigned SeptetW = 7;
    localparam int unsigned CharW   = 8;
    localparam int unsigned ResCntW = 3;
    // Residue depth at which one octet completes two septets.
    localparam logic [ResCntW-1:0] ResFull = 3'd6;

    // Up to two characters produced by one octet; slot 0 fills first.
    typedef struct packed {
        logic [1:0]       count;
        logic [CharW-1:0] char0;
        logic             last0;
        logic [CharW-1:0] char1;
        logic             last1;
    } t_pair;

    localparam logic [CharW-1:0] AlphabetRom [128] = '{
        8'h40, 8'ha3, 8'h24, 8'ha5, 8'he8, 8'he9, 8'hf9, 8'hec,
        8'hf2, 8'hc7, 8'h0a, 8'hd8, 8'hf8, 8'h0d, 8'hc5, 8'he5,
        8'h44, 8'h5f, 8'h46, 8'h47, 8'h4c, 8'h57, 8'h50, 8'h59,
        8'h53, 8'h51, 8'h58, 8'h00, 8'hc6, 8'he6, 8'hdf, 8'hc9,
        8'h20, 8'h21, 8'h22, 8'h23, 8'ha4, 8'h25, 8'h26, 8'h27,
        8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
        8'ha1, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
        8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
        8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
        8'h58, 8'h59, 8'h5a, 8'hc4, 8'hd6, 8'hd1, 8'hdc, 8'ha7,
        8'hbf, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
        8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
        8'h78, 8'h79, 8'h7a, 8'he4, 8'hf6, 8'hf1, 8'hfc, 8'he0
    };

    function automatic logic [CharW-1:0] alphabet_lookup(input logic [SeptetW-1:0] septet);
        alphabet_lookup = AlphabetRom[septet];
    endfunction

endpackage

FILE: hw/rtl/gsup_unpack.sv
// ----------------------------------------------------------------------------
// gsup_unpack
// Septet extraction, character counting and ROM mapping for one octet.
// ----------------------------------------------------------------------------
module gsup_unpack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_octet,
    input  logic                 i_start,
    input  logic [7:0]           i_count,
    output gsup_pkg::t_pair      o_pair
);

    logic [gsup_pkg::SeptetW-1:0] r_res_bits, n_res_bits;
    logic [gsup_pkg::ResCntW-1:0] r_res_cnt,  n_res_cnt;
    logic [7:0]                   r_emitted,  n_emitted;
    logic [7:0]                   r_expected, n_expected;

    logic [gsup_pkg::SeptetW-1:0] res_mask;
    logic [gsup_pkg::SeptetW-1:0] base_bits;
    logic [gsup_pkg::ResCntW-1:0] base_cnt;
    logic [7:0]                   base_emitted;
    logic [14:0]                  acc;
    logic                         two;
    logic                         emit0;
    logic                         emit1;
    logic [7:0]                   emitted1;

    always_comb begin
        // start clears residue and count before the octet is used
        base_bits    = i_start ? '0 : r_res_bits;
        base_cnt     = (i_start || r_res_cnt > gsup_pkg::ResFull) ? '0 : r_res_cnt;
        base_emitted = i_start ? '0 : r_emitted;
        n_expected   = i_start ? i_count : r_expected;

        res_mask = gsup_pkg::SeptetW'((8'd1 << base_cnt) - 8'd1);
        acc      = {8'h00, base_bits & res_mask} | ({7'h00, i_octet} << base_cnt);
        two      = (base_cnt == gsup_pkg::ResFull);

        emit0    = (base_emitted < n_expected);
        emitted1 = emit0 ? base_emitted + 8'd1 : base_emitted;
        emit1    = two && (emitted1 < n_expected);
        n_emitted = emit1 ? emitted1 + 8'd1 : emitted1;

        n_res_bits = two ? '0 : acc[13:7];
        n_res_cnt  = two ? '0 : base_cnt + 3'd1;

        o_pair.count = {1'b0, emit0} + {1'b0, emit1};
        o_pair.char0 = gsup_pkg::alphabet_lookup(acc[6:0]);
        o_pair.last0 = (base_emitted + 8'd1 == n_expected);
        o_pair.char1 = gsup_pkg::alphabet_lookup(acc[13:7]);
        o_pair.last1 = (emitted1 + 8'd1 == n_expected);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits <= '0;
            r_res_cnt  <= '0;
            r_emitted  <= '0;
            r_expected <= '0;
        end else if (i_accept) begin
            r_res_bits <= n_res_bits;
            r_res_cnt  <= n_res_cnt;
            r_emitted  <= n_emitted;
            r_expected <= n_expected;
        end
    end

endmodule

FILE: hw/rtl/gsup_outbuf.sv
// ----------------------------------------------------------------------------
// gsup_outbuf
// Two-slot result register; drains one character per cycle while i_take is high.
// ----------------------------------------------------------------------------
module gsup_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  gsup_pkg::t_pair      i_pair,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_take,
    output logic [7:0]           o_char,
    output logic                 o_last
);

    logic [1:0]      r_left, n_left;
    logic            r_head, n_head;
    gsup_pkg::t_pair r_pair;

    assign o_valid = (r_left != 2'd0);
    // take a new pair once the buffer is empty or its last entry leaves now
    assign o_ready = (r_left == 2'd0) || (r_left == 2'd1 && i_take);
    assign o_char  = r_head ? r_pair.char1 : r_pair.char0;
    assign o_last  = r_head ? r_pair.last1 : r_pair.last0;

    always_comb begin
        n_left = r_left;
        n_head = r_head;
        priority if (i_load) begin
            n_left = i_pair.count;
            n_head = 1'b0;
        end else if (i_take && o_valid) begin
            n_left = r_left - 2'd1;
            n_head = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_head <= 1'b0;
        end else begin
            r_left <= n_left;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pair <= i_pair;
        end
    end

endmodule

FILE: hw/rtl/gsm7_septet_unpack_to_latin1.sv
// ----------------------------------------------------------------------------
// gsm7_septet_unpack_to_latin1
// Packed GSM 7-bit user data to Latin-1 characters, one octet per request.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one packed octet per request. tuser = start of
//    message; on that request tdata[15:8] gives the character count.
//  - Master stream carries one Latin-1 character per request; tlast marks
//    the final character of the message.
//  - Latency: the first character of an octet is visible on the master side the
//    cycle after its octet is taken.
//  - Throughput: one octet per cycle while the master side takes each character.
//    An octet that completes two septets holds its two characters in the result
//    register, so the following octet is not taken until the second of them
//    leaves. The two-slot result register sets this limit.
//  - Octets past the character count (padding) yield nothing.
//  - Reset (synchronous, active low) empties the result register and
//    clears residue and counts; nothing is emitted until a start arrives.
//  - Master stall: the result register holds; the slave side keeps taking
//    octets only while the register can absorb the next result.
// ----------------------------------------------------------------------------
module gsm7_septet_unpack_to_latin1 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] packed_octet, [15:8] char_count
    input  logic        i_s_axis_tuser,   // [0] start_of_message
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] latin1_char
    output logic        o_m_axis_tlast    // last_char
);

    logic            in_accept;
    gsup_pkg::t_pair pair;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // residue / count state and ROM mapping
    gsup_unpack u_unpack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_octet  (i_s_axis_tdata[7:0]),
        .i_start  (i_s_axis_tuser),
        .i_count  (i_s_axis_tdata[15:8]),
        .o_pair   (pair)
    );

    // result register, up to two characters per octet
    gsup_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_pair   (pair),
        .o_ready  (o_s_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .i_take   (i_m_axis_tready),
        .o_char   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast)
    );

endmodule
